// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/aptf_pkg.sv =====
`default_nettype none

package aptf_pkg;

   localparam int RATE_W     = 20;
   localparam int BUS_W      = 13;
   localparam int TONE_W     = 15;
   localparam int SAMPLE_W   = 16;
   localparam int ALT_W      = 8;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int PHASE_W    = 32;
   localparam int ACC_W      = RATE_W + 1;
   localparam int DIVIDEND_W = TONE_W + PHASE_W;
   localparam int DIVISOR_W  = RATE_W;
   localparam int QUOT_W     = PHASE_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int WAVE_IDX_W = 8;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PACKET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET_IF = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUS_RATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_HZ  = 2'd3;

   localparam logic [ALT_W-1:0] ALT_OFF   = 8'd0;
   localparam logic [ALT_W-1:0] ALT_PCM16 = 8'd1;

   localparam logic [RATE_W-1:0] FALLBACK_RATE = 20'd44100;
   localparam logic [RATE_W-1:0] MIN_RATE_RST  = 20'd33800;
   localparam logic [RATE_W-1:0] MAX_RATE_RST  = 20'd44100;
   localparam logic [BUS_W-1:0]  BUS_RATE_RST  = 13'd1000;
   localparam logic [TONE_W-1:0] TONE_HZ_RST   = 15'd440;

   localparam logic DIV_FRAMES = 1'b0;
   localparam logic DIV_TONE   = 1'b1;

   typedef struct packed {
      logic push;
      logic set_alt;
      logic close;
      logic capture;
      logic div_start;
      logic div_sel;
      logic take_frames;
      logic take_step;
      logic load_out;
      logic emit_ack;
   } aptf_cmd_type;

   typedef struct packed {
      logic stream_on;
      logic div_done;
      logic want_zero;
      logic last_frame;
   } aptf_status_type;

   // one full sine period, peak 30000
   localparam logic signed [SAMPLE_W-1:0] WAVE_TABLE [0:255] = '{
      16'sd0, 16'sd736, 16'sd1472, 16'sd2207, 16'sd2941, 16'sd3672, 16'sd4402, 16'sd5129,
      16'sd5853, 16'sd6573, 16'sd7289, 16'sd8001, 16'sd8709, 16'sd9410, 16'sd10107,
      16'sd10797,
      16'sd11481, 16'sd12157, 16'sd12827, 16'sd13488, 16'sd14142, 16'sd14787, 16'sd15423,
      16'sd16050,
      16'sd16667, 16'sd17274, 16'sd17871, 16'sd18457, 16'sd19032, 16'sd19595, 16'sd20147,
      16'sd20686,
      16'sd21213, 16'sd21727, 16'sd22229, 16'sd22716, 16'sd23190, 16'sd23650, 16'sd24096,
      16'sd24528,
      16'sd24944, 16'sd25346, 16'sd25732, 16'sd26103, 16'sd26458, 16'sd26797, 16'sd27120,
      16'sd27426,
      16'sd27716, 16'sd27990, 16'sd28246, 16'sd28486, 16'sd28708, 16'sd28913, 16'sd29101,
      16'sd29271,
      16'sd29424, 16'sd29558, 16'sd29675, 16'sd29774, 16'sd29856, 16'sd29919, 16'sd29964,
      16'sd29991,
      16'sd30000, 16'sd29991, 16'sd29964, 16'sd29919, 16'sd29856, 16'sd29774, 16'sd29675,
      16'sd29558,
      16'sd29424, 16'sd29271, 16'sd29101, 16'sd28913, 16'sd28708, 16'sd28486, 16'sd28246,
      16'sd27990,
      16'sd27716, 16'sd27426, 16'sd27120, 16'sd26797, 16'sd26458, 16'sd26103, 16'sd25732,
      16'sd25346,
      16'sd24944, 16'sd24528, 16'sd24096, 16'sd23650, 16'sd23190, 16'sd22716, 16'sd22229,
      16'sd21727,
      16'sd21213, 16'sd20686, 16'sd20147, 16'sd19595, 16'sd19032, 16'sd18457, 16'sd17871,
      16'sd17274,
      16'sd16667, 16'sd16050, 16'sd15423, 16'sd14787, 16'sd14142, 16'sd13488, 16'sd12827,
      16'sd12157,
      16'sd11481, 16'sd10797, 16'sd10107, 16'sd9410, 16'sd8709, 16'sd8001, 16'sd7289,
      16'sd6573,
      16'sd5853, 16'sd5129, 16'sd4402, 16'sd3672, 16'sd2941, 16'sd2207, 16'sd1472, 16'sd736,
      16'sd0, -16'sd736, -16'sd1472, -16'sd2207, -16'sd2941, -16'sd3672, -16'sd4402,
      -16'sd5129,
      -16'sd5853, -16'sd6573, -16'sd7289, -16'sd8001, -16'sd8709, -16'sd9410, -16'sd10107,
      -16'sd10797,
      -16'sd11481, -16'sd12157, -16'sd12827, -16'sd13488, -16'sd14142, -16'sd14787,
      -16'sd15423, -16'sd16050,
      -16'sd16667, -16'sd17274, -16'sd17871, -16'sd18457, -16'sd19032, -16'sd19595,
      -16'sd20147, -16'sd20686,
      -16'sd21213, -16'sd21727, -16'sd22229, -16'sd22716, -16'sd23190, -16'sd23650,
      -16'sd24096, -16'sd24528,
      -16'sd24944, -16'sd25346, -16'sd25732, -16'sd26103, -16'sd26458, -16'sd26797,
      -16'sd27120, -16'sd27426,
      -16'sd27716, -16'sd27990, -16'sd28246, -16'sd28486, -16'sd28708, -16'sd28913,
      -16'sd29101, -16'sd29271,
      -16'sd29424, -16'sd29558, -16'sd29675, -16'sd29774, -16'sd29856, -16'sd29919,
      -16'sd29964, -16'sd29991,
      -16'sd30000, -16'sd29991, -16'sd29964, -16'sd29919, -16'sd29856, -16'sd29774,
      -16'sd29675, -16'sd29558,
      -16'sd29424, -16'sd29271, -16'sd29101, -16'sd28913, -16'sd28708, -16'sd28486,
      -16'sd28246, -16'sd27990,
      -16'sd27716, -16'sd27426, -16'sd27120, -16'sd26797, -16'sd26458, -16'sd26103,
      -16'sd25732, -16'sd25346,
      -16'sd24944, -16'sd24528, -16'sd24096, -16'sd23650, -16'sd23190, -16'sd22716,
      -16'sd22229, -16'sd21727,
      -16'sd21213, -16'sd20686, -16'sd20147, -16'sd19595, -16'sd19032, -16'sd18457,
      -16'sd17871, -16'sd17274,
      -16'sd16667, -16'sd16050, -16'sd15423, -16'sd14787, -16'sd14142, -16'sd13488,
      -16'sd12827, -16'sd12157,
      -16'sd11481, -16'sd10797, -16'sd10107, -16'sd9410, -16'sd8709, -16'sd8001,
      -16'sd7289, -16'sd6573,
      -16'sd5853, -16'sd5129, -16'sd4402, -16'sd3672, -16'sd2941, -16'sd2207, -16'sd1472,
      -16'sd736
   };

endpackage

`default_nettype wire

// ===== rtl/aptf_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. Only the low QUOT_W
// quotient bits are kept.
module aptf_div import aptf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [QUOT_W-1:0]          quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam logic [DIV_CNT_W-1:0] LAST_ITER = DIV_CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [QUOT_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    partial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   always_comb begin
      partial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = partial - {1'b0, dsr_ff};
      ge      = (partial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in = {quo_ff[QUOT_W-2:0], ge};
         rem_in = ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/aptf_datapath.sv =====
`default_nettype none

module aptf_datapath import aptf_pkg::*; #(
   parameter int RING_DEPTH        = 2048,
   parameter int MAX_PACKET_FRAMES = 48
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire aptf_cmd_type                 cmd,
   output aptf_status_type                   status,
   input  wire logic signed [SAMPLE_W-1:0]   req_in_left,
   input  wire logic signed [SAMPLE_W-1:0]   req_in_right,
   input  wire logic [RATE_W-1:0]            req_measured_rate,
   input  wire logic [ALT_W-1:0]             req_alt_setting,
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wr_data,
   output logic signed [SAMPLE_W-1:0]        rsp_out_left,
   output logic signed [SAMPLE_W-1:0]        rsp_out_right,
   output logic                              rsp_from_tone,
   output logic                              rsp_last
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int FRM_W = $clog2(MAX_PACKET_FRAMES + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
   localparam logic [FRM_W-1:0] FRM_CAP  = FRM_W'(MAX_PACKET_FRAMES);

   logic [RATE_W-1:0]   min_rate_ff, min_rate_in;
   logic [RATE_W-1:0]   max_rate_ff, max_rate_in;
   logic [BUS_W-1:0]    bus_rate_ff, bus_rate_in;
   logic [TONE_W-1:0]   tone_hz_ff, tone_hz_in;
   logic [ALT_W-1:0]    active_alt_ff, active_alt_in;
   logic [BUS_W-1:0]    remainder_ff, remainder_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FRM_W-1:0]    want_ff, want_in;
   logic [FRM_W-1:0]    frame_idx_ff, frame_idx_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [PHASE_W-1:0]  step_ff, step_in;

   logic [2*SAMPLE_W-1:0]        ring [RING_DEPTH];
   logic [2*SAMPLE_W-1:0]        rd_data_ff;
   logic signed [SAMPLE_W-1:0]   out_left_ff, out_right_ff;
   logic                         out_tone_ff, out_last_ff;

   logic                    ring_we;
   logic                    clear_stream;
   logic [RATE_W-1:0]       clamped;
   logic [ACC_W-1:0]        acc;
   logic [BUS_W-1:0]        bus_eff;
   logic [RATE_W-1:0]       tone_rate;
   logic [DIVIDEND_W-1:0]   div_dividend;
   logic [DIVISOR_W-1:0]    div_divisor;
   logic                    div_done;
   logic [QUOT_W-1:0]       div_quo;
   logic [DIVISOR_W-1:0]    div_rem;
   logic signed [SAMPLE_W-1:0] tone_sample;
   logic                    ring_empty;

   // operand selection for the shared divider
   always_comb begin
      acc       = ACC_W'(remainder_ff) + ACC_W'(rate_ff);
      bus_eff   = (bus_rate_ff == '0) ? BUS_W'(1) : bus_rate_ff;
      tone_rate = (rate_ff != '0) ? rate_ff :
                  ((max_rate_ff != '0) ? max_rate_ff : FALLBACK_RATE);
      if (cmd.div_sel == DIV_TONE) begin
         div_dividend = {tone_hz_ff, {PHASE_W{1'b0}}};
         div_divisor  = tone_rate;
      end else begin
         div_dividend = DIVIDEND_W'(acc);
         div_divisor  = DIVISOR_W'(bus_eff);
      end
   end

   aptf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      // below min gives min even when min sits above max
      if (req_measured_rate < min_rate_ff) begin
         clamped = min_rate_ff;
      end else if (req_measured_rate > max_rate_ff) begin
         clamped = max_rate_ff;
      end else begin
         clamped = req_measured_rate;
      end
   end

   assign ring_empty   = (count_ff == '0);
   assign ring_we      = cmd.push && (count_ff != CNT_FULL);
   assign clear_stream = cmd.close || (cmd.set_alt && (req_alt_setting == ALT_OFF));
   assign tone_sample  = WAVE_TABLE[phase_ff[PHASE_W-1 -: WAVE_IDX_W]];

   always_comb begin
      min_rate_in   = min_rate_ff;
      max_rate_in   = max_rate_ff;
      bus_rate_in   = bus_rate_ff;
      tone_hz_in    = tone_hz_ff;
      active_alt_in = active_alt_ff;
      remainder_in  = remainder_ff;
      phase_in      = phase_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      want_in       = want_ff;
      frame_idx_in  = frame_idx_ff;
      rate_in       = rate_ff;
      step_in       = step_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_RATE: min_rate_in = csr_wr_data[RATE_W-1:0];
            CSR_MAX_RATE: max_rate_in = csr_wr_data[RATE_W-1:0];
            CSR_BUS_RATE: bus_rate_in = csr_wr_data[BUS_W-1:0];
            CSR_TONE_HZ:  tone_hz_in  = csr_wr_data[TONE_W-1:0];
            default: ;
         endcase
      end

      if (ring_we) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end
      if (cmd.set_alt) begin
         active_alt_in = req_alt_setting;
      end
      if (cmd.close) begin
         active_alt_in = ALT_OFF;
      end
      if (clear_stream) begin
         remainder_in = '0;
         phase_in     = '0;
         rd_ptr_in    = '0;
         wr_ptr_in    = '0;
         count_in     = '0;
      end

      if (cmd.capture) begin
         rate_in = clamped;
      end
      if (cmd.take_frames) begin
         remainder_in = div_rem[BUS_W-1:0];
         want_in      = (div_quo > QUOT_W'(MAX_PACKET_FRAMES)) ? FRM_CAP
                                                               : div_quo[FRM_W-1:0];
         frame_idx_in = '0;
      end
      if (cmd.take_step) begin
         step_in = div_quo;
      end
      if (cmd.emit_ack) begin
         frame_idx_in = frame_idx_ff + FRM_W'(1);
         if (out_tone_ff) begin
            phase_in = phase_ff + step_ff;
         end else begin
            rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
            count_in  = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rate_ff   <= MIN_RATE_RST;
         max_rate_ff   <= MAX_RATE_RST;
         bus_rate_ff   <= BUS_RATE_RST;
         tone_hz_ff    <= TONE_HZ_RST;
         active_alt_ff <= ALT_OFF;
         remainder_ff  <= '0;
         phase_ff      <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         want_ff       <= '0;
         frame_idx_ff  <= '0;
      end else begin
         min_rate_ff   <= min_rate_in;
         max_rate_ff   <= max_rate_in;
         bus_rate_ff   <= bus_rate_in;
         tone_hz_ff    <= tone_hz_in;
         active_alt_ff <= active_alt_in;
         remainder_ff  <= remainder_in;
         phase_ff      <= phase_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         want_ff       <= want_in;
         frame_idx_ff  <= frame_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
      step_ff <= step_in;
   end

   // ring memory, right sample in the upper half
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[wr_ptr_ff] <= {req_in_right, req_in_left};
      end
      rd_data_ff <= ring[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (ring_empty) begin
            out_left_ff  <= tone_sample;
            out_right_ff <= tone_sample;
         end else begin
            out_left_ff  <= rd_data_ff[SAMPLE_W-1:0];
            out_right_ff <= rd_data_ff[2*SAMPLE_W-1:SAMPLE_W];
         end
         out_tone_ff <= ring_empty;
         out_last_ff <= status.last_frame;
      end
   end

   always_comb begin
      status.stream_on  = (req_alt_setting == ALT_PCM16) && (active_alt_ff == ALT_PCM16);
      status.div_done   = div_done;
      status.want_zero  = (want_ff == '0);
      status.last_frame = ((frame_idx_ff + FRM_W'(1)) == want_ff);
   end

   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;
   assign rsp_from_tone = out_tone_ff;
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/aptf_ctrl.sv =====
`default_nettype none

module aptf_ctrl import aptf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_command,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire aptf_status_type   status,
   output aptf_cmd_type           cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV1_GO   = 3'd1;
   localparam logic [2:0] S_DIV1_WAIT = 3'd2;
   localparam logic [2:0] S_DIV2_GO   = 3'd3;
   localparam logic [2:0] S_DIV2_WAIT = 3'd4;
   localparam logic [2:0] S_FETCH     = 3'd5;
   localparam logic [2:0] S_LOAD      = 3'd6;
   localparam logic [2:0] S_EMIT      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_command)
                  CMD_PUSH:   cmd.push    = 1'b1;
                  CMD_SET_IF: cmd.set_alt = 1'b1;
                  CMD_CLOSE:  cmd.close   = 1'b1;
                  CMD_PACKET: begin
                     if (status.stream_on) begin
                        cmd.capture = 1'b1;
                        state_in    = S_DIV1_GO;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV1_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FRAMES;
            state_in      = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            cmd.div_sel = DIV_FRAMES;
            if (status.div_done) begin
               cmd.take_frames = 1'b1;
               state_in        = S_DIV2_GO;
            end
         end
         S_DIV2_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TONE;
            state_in      = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            cmd.div_sel = DIV_TONE;
            if (status.div_done) begin
               cmd.take_step = 1'b1;
               state_in      = status.want_zero ? S_IDLE : S_FETCH;
            end
         end
         // ring read data is registered and lands in the cycle after the pointer settles
         S_FETCH: state_in = S_LOAD;
         S_LOAD: begin
            cmd.load_out = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_acc) begin
               cmd.emit_ack = 1'b1;
               state_in     = status.last_frame ? S_IDLE : S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/audio_packet_pacer_tone_fill.sv =====
// Stereo audio packet pacer with tone fill. Push, set-interface and close
// words are handled in the idle state as they are taken, so they can arrive
// back to back. A packet request with streaming on (alt 1 both in the word
// and on the endpoint) runs the shared 47-step restoring divider twice, once
// for the frame count and remainder and once for the tone phase step, then
// emits each frame through a ring read, an output load and a handshake; a
// full packet holds 48 frames. Frames come from the capture ring first and
// are padded with a sine tone when the ring runs dry; pushes into a full
// ring are dropped. The csr registers may only be written while no request
// is in flight.
`default_nettype none

`include "assert_macros.svh"

module audio_packet_pacer_tone_fill import aptf_pkg::*; #(
   parameter int RING_DEPTH        = 2048,
   parameter int MAX_PACKET_FRAMES = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [CMD_W-1:0]            req_command,
   input  wire logic signed [SAMPLE_W-1:0]  req_in_left,
   input  wire logic signed [SAMPLE_W-1:0]  req_in_right,
   input  wire logic [RATE_W-1:0]           req_measured_rate,
   input  wire logic [ALT_W-1:0]            req_alt_setting,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]       rsp_out_left,
   output logic signed [SAMPLE_W-1:0]       rsp_out_right,
   output logic                             rsp_from_tone,
   output logic                             rsp_last,
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wr_data
);

   aptf_cmd_type    cmd;
   aptf_status_type status;

   aptf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   aptf_datapath #(
      .RING_DEPTH        (RING_DEPTH),
      .MAX_PACKET_FRAMES (MAX_PACKET_FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_in_left       (req_in_left),
      .req_in_right      (req_in_right),
      .req_measured_rate (req_measured_rate),
      .req_alt_setting   (req_alt_setting),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_out_left      (rsp_out_left),
      .rsp_out_right     (rsp_out_right),
      .rsp_from_tone     (rsp_from_tone),
      .rsp_last          (rsp_last)
   );

   `ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready, "req taken during packet")
   `ASSERT_NEXT(a_packet_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      !req_ready, "packet ended before its last word")
   `ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last,
      req_ready && !rsp_valid, "not idle after last word")
   `ASSERT_NOW(a_emit_only_when_done, clock, reset, cmd.emit_ack, rsp_valid && rsp_ready,
      "frame retired without handshake")

endmodule

`default_nettype wire
